@@ rtl/bifs_pkg.sv @@
package bifs_pkg;

    localparam int VALUE_W  = 32;
    localparam int ENTRY_W  = 4;
    localparam int SEG_W    = 4;
    localparam int FRAC_W   = 8;
    localparam int CFG_W    = 5;
    localparam int PROD_W   = VALUE_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(FRAC_W + 1);

    localparam logic [CFG_W-1:0] POINTS_RESET = CFG_W'(16);

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHK_LO = 7'b0000010,
        S_CHK_HI = 7'b0000100,
        S_PROBE  = 7'b0001000,
        S_SUB    = 7'b0010000,
        S_MUL    = 7'b0100000,
        S_DIV    = 7'b1000000
    } state_t;

endpackage

@@ rtl/breakpoint_index_fraction_search.sv @@
// Breakpoint table with a binary-search lookup. A word with kind 0 stores value into
// table entry entry_index (taken modulo MAX_POINTS) and gives no result.
// A word with kind 1 searches the first points_in_use entries for the largest breakpoint
// not above value and returns its segment_index and fraction = floor(255*(value-lo)/(hi-lo)),
// with fraction 0 when the target clamps to either end of the table. All probes go
// through one table read port with registered data, one probe per cycle, and the
// fraction comes from an eight-step restoring divider, one quotient bit per cycle. A
// lookup that clamps at the low end stops after checking entry 0, one at the high end
// after checking the last entry in use; an interior lookup probes, subtracts, multiplies
// and divides, then registers its result. in_stall stays high while a lookup is in progress,
// and one finished result can wait in the output register while new words are taken.
module breakpoint_index_fraction_search
    import bifs_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [CFG_W-1:0]          cfg_write_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      kind,
    input  logic [ENTRY_W-1:0]        entry_index,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SEG_W-1:0]          segment_index,
    output logic [FRAC_W-1:0]         fraction
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int RED_W = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
    localparam int RED_STEPS = 8;

    logic signed [VALUE_W-1:0] mem [MAX_POINTS];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W-1:0]          wr_addr;
    logic                      wr_en;
    logic [RED_W-1:0]          wr_red;

    state_t                    state_reg, state_next;
    logic [CFG_W-1:0]          points_in_use_reg;
    logic [IDX_W-1:0]          lo_reg, lo_next;
    logic [IDX_W-1:0]          hi_reg, hi_next;
    logic signed [VALUE_W-1:0] target_reg, target_next;
    logic signed [VALUE_W-1:0] lo_val_reg, lo_val_next;
    logic signed [VALUE_W-1:0] hi_val_reg, hi_val_next;
    logic [VALUE_W-1:0]        num_reg, num_next;
    logic [VALUE_W-1:0]        den_reg, den_next;
    logic [VALUE_W-1:0]        rem_reg, rem_next;
    logic [FRAC_W-1:0]         quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic [SEG_W-1:0]          segment_index_reg, segment_index_next;
    logic [FRAC_W-1:0]         fraction_reg, fraction_next;

    logic [CNT_W-1:0]          used;
    logic [CNT_W-1:0]          used_m1;
    logic [IDX_W:0]            mid_sum_cur;
    logic [IDX_W:0]            mid_sum_nxt;
    logic [IDX_W:0]            lo_plus1_cur;
    logic [IDX_W:0]            lo_plus1_nxt;
    logic [VALUE_W:0]          num_diff;
    logic [VALUE_W:0]          den_diff;
    logic [PROD_W-1:0]         prod;
    logic [VALUE_W:0]          shifted;
    logic                      div_ge;
    logic                      accept;

    // effective point count, clamped to 1..MAX_POINTS
    always_comb
    begin
        if (points_in_use_reg == '0)
        begin
            used = CNT_W'(1);
        end
        else if (int'(points_in_use_reg) > MAX_POINTS)
        begin
            used = CNT_W'(MAX_POINTS);
        end
        else
        begin
            used = CNT_W'(points_in_use_reg);
        end
        used_m1 = used - CNT_W'(1);
    end

    // write index modulo table depth
    always_comb
    begin
        wr_red = RED_W'(entry_index);
        for (int k = 0; k < RED_STEPS; k++)
        begin
            if (wr_red >= RED_W'(MAX_POINTS))
            begin
                wr_red = wr_red - RED_W'(MAX_POINTS);
            end
        end
        wr_addr = wr_red[IDX_W-1:0];
    end

    assign accept       = in_valid && !in_stall;
    assign wr_en        = accept && (kind == KIND_WRITE);
    assign in_stall     = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign mid_sum_cur  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign lo_plus1_cur = {1'b0, lo_reg} + (IDX_W+1)'(1);
    assign num_diff     = {target_reg[VALUE_W-1], target_reg}
                          - {lo_val_reg[VALUE_W-1], lo_val_reg};
    assign den_diff     = {hi_val_reg[VALUE_W-1], hi_val_reg}
                          - {lo_val_reg[VALUE_W-1], lo_val_reg};
    assign prod         = {num_reg, FRAC_W'(0)} - PROD_W'(num_reg);
    assign shifted      = {rem_reg, quo_reg[FRAC_W-1]};
    assign div_ge       = shifted >= {1'b0, den_reg};

    always_comb
    begin
        state_next         = state_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        target_next        = target_reg;
        lo_val_next        = lo_val_reg;
        hi_val_next        = hi_val_reg;
        num_next           = num_reg;
        den_next           = den_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        cnt_next           = cnt_reg;
        rd_addr            = '0;
        mid_sum_nxt        = mid_sum_cur;
        lo_plus1_nxt       = lo_plus1_cur;
        out_valid_next     = out_valid_reg && out_stall;
        segment_index_next = segment_index_reg;
        fraction_next      = fraction_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (accept && (kind == KIND_LOOKUP))
                begin
                    target_next = value;
                    lo_next     = '0;
                    hi_next     = used_m1[IDX_W-1:0];
                    quo_next    = '0;
                    state_next  = S_CHK_LO;
                end
            end
            S_CHK_LO:
            begin
                rd_addr = hi_reg;
                if (target_reg > rd_data_reg)
                begin
                    lo_val_next = rd_data_reg;
                    state_next  = S_CHK_HI;
                end
                else
                begin
                    state_next = S_DIV;
                    cnt_next   = DIV_CNT_W'(FRAC_W);
                end
            end
            S_CHK_HI:
            begin
                rd_addr = mid_sum_cur[IDX_W:1];
                if (target_reg >= rd_data_reg)
                begin
                    lo_next    = hi_reg;
                    state_next = S_DIV;
                    cnt_next   = DIV_CNT_W'(FRAC_W);
                end
                else
                begin
                    hi_val_next = rd_data_reg;
                    if ({1'b0, hi_reg} == lo_plus1_cur)
                    begin
                        state_next = S_SUB;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (target_reg >= rd_data_reg)
                begin
                    lo_next     = mid_sum_cur[IDX_W:1];
                    lo_val_next = rd_data_reg;
                end
                else
                begin
                    hi_next     = mid_sum_cur[IDX_W:1];
                    hi_val_next = rd_data_reg;
                end
                mid_sum_nxt  = {1'b0, lo_next} + {1'b0, hi_next};
                lo_plus1_nxt = {1'b0, lo_next} + (IDX_W+1)'(1);
                rd_addr      = mid_sum_nxt[IDX_W:1];
                if ({1'b0, hi_next} == lo_plus1_nxt)
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                num_next   = num_diff[VALUE_W-1:0];
                den_next   = den_diff[VALUE_W-1:0];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // 255*num, high part seeds the remainder, low byte shifts in
                rem_next   = prod[PROD_W-1:FRAC_W];
                quo_next   = prod[FRAC_W-1:0];
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg != DIV_CNT_W'(FRAC_W))
                begin
                    rem_next = div_ge ? shifted[VALUE_W-1:0] - den_reg : shifted[VALUE_W-1:0];
                    quo_next = {quo_reg[FRAC_W-2:0], div_ge};
                    cnt_next = cnt_reg + DIV_CNT_W'(1);
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    segment_index_next = SEG_W'(lo_reg);
                    fraction_next      = quo_reg;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            points_in_use_reg <= POINTS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                points_in_use_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg            <= lo_next;
        hi_reg            <= hi_next;
        target_reg        <= target_next;
        lo_val_reg        <= lo_val_next;
        hi_val_reg        <= hi_val_next;
        num_reg           <= num_next;
        den_reg           <= den_next;
        rem_reg           <= rem_next;
        quo_reg           <= quo_next;
        cnt_reg           <= cnt_next;
        segment_index_reg <= segment_index_next;
        fraction_reg      <= fraction_next;
    end

    assign out_valid     = out_valid_reg;
    assign segment_index = segment_index_reg;
    assign fraction      = fraction_reg;

endmodule

@@ tb/breakpoint_index_fraction_search_tb.sv @@
module breakpoint_index_fraction_search_tb;
    import bifs_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int WORD_TARGET = 1150;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [SEG_W-1:0]  seg;
        logic [FRAC_W-1:0] frac;
    } segment_result_t;

    class breakpoint_shadow;
        logic signed [VALUE_W-1:0] breakpoint_vals [TABLE_DEPTH];
        logic [CFG_W-1:0]          points_cfg;
        segment_result_t           expected_segments [$];

        function new();
            points_cfg = POINTS_RESET;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                breakpoint_vals[i] = '0;
            end
        endfunction

        function void set_points(logic [CFG_W-1:0] v);
            points_cfg = v;
        endfunction

        function int used_points();
            int n;
            n = points_cfg;
            if (n < 1)
                n = 1;
            if (n > TABLE_DEPTH)
                n = TABLE_DEPTH;
            return n;
        endfunction

        function segment_result_t search_segment(logic signed [VALUE_W-1:0] target);
            int lo_i;
            int hi_i;
            int mid;
            longint num;
            longint den;
            segment_result_t r;
            lo_i = 0;
            r.frac = '0;
            if (target > breakpoint_vals[0])
            begin
                hi_i = used_points() - 1;
                if (target >= breakpoint_vals[hi_i])
                begin
                    lo_i = hi_i;
                end
                else
                begin
                    while (hi_i > lo_i + 1)
                    begin
                        mid = (hi_i + lo_i) >> 1;
                        if (target >= breakpoint_vals[mid])
                            lo_i = mid;
                        else
                            hi_i = mid;
                    end
                    num = longint'(target) - longint'(breakpoint_vals[lo_i]);
                    den = longint'(breakpoint_vals[lo_i + 1]) - longint'(breakpoint_vals[lo_i]);
                    if (den > 0 && num >= 0)
                        r.frac = FRAC_W'((num * 255) / den);
                end
            end
            r.seg = SEG_W'(lo_i);
            return r;
        endfunction

        function void note_word(logic k, logic [ENTRY_W-1:0] idx,
                                logic signed [VALUE_W-1:0] v);
            if (k == KIND_WRITE)
                breakpoint_vals[idx % TABLE_DEPTH] = v;
            else
                expected_segments.push_back(search_segment(v));
        endfunction

        function string check_segment(logic [SEG_W-1:0] seg, logic [FRAC_W-1:0] frac);
            segment_result_t want;
            string msg;
            msg = "";
            if (expected_segments.size() == 0)
                return $sformatf("result with no lookup pending: segment_index %0d fraction %0d",
                                 seg, frac);
            want = expected_segments.pop_front();
            if (seg !== want.seg)
                msg = $sformatf("segment_index %0d, want %0d", seg, want.seg);
            if (frac !== want.frac)
            begin
                if (msg != "")
                    msg = {msg, "; "};
                msg = {msg, $sformatf("fraction %0d, want %0d", frac, want.frac)};
            end
            return msg;
        endfunction

        function int pending();
            return expected_segments.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write_en = 1'b0;
    logic [CFG_W-1:0]          cfg_write_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      kind = KIND_WRITE;
    logic [ENTRY_W-1:0]        entry_index = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [SEG_W-1:0]          segment_index;
    logic [FRAC_W-1:0]         fraction;

    breakpoint_shadow shadow;
    int    mismatch_count = 0;
    int    words_sent = 0;
    int    burst_left = 0;
    int    phase_count = 0;
    string result_msg;
    int    stall_mode = 0;
    int    stall_mode_left = 0;
    int    stall_tick = 0;

    int directed_points [TABLE_DEPTH] = '{
        -2147483647 - 1, -1000000000, -65536, -100, -1, 0, 1, 2,
        255, 1000, 65536, 65536, 1000000, 1000000000, 2147483646, 2147483647
    };

    breakpoint_index_fraction_search uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .entry_index    (entry_index),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .segment_index  (segment_index),
        .fraction       (fraction)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    task report_mismatch(string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            shadow.note_word(kind, entry_index, value);
        if (rst_n && out_valid && !out_stall)
        begin
            result_msg = shadow.check_segment(segment_index, fraction);
            if (result_msg != "")
                report_mismatch(result_msg);
        end
    end

    // receiver stall: modes of random length
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(32, 200);
        end
        else
        begin
            stall_mode_left--;
        end
        stall_tick++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_tick % 23) < 9);
        endcase
    end

    task send_word(logic k, logic [ENTRY_W-1:0] idx, logic signed [VALUE_W-1:0] v);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid    <= 1'b1;
        kind        <= k;
        entry_index <= idx;
        value       <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task set_points(logic [CFG_W-1:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        shadow.set_points(v);
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function logic signed [VALUE_W-1:0] pick_target();
        int n;
        int i;
        longint lo;
        longint span;
        n = shadow.used_points();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return shadow.breakpoint_vals[$urandom_range(0, TABLE_DEPTH - 1)];
            3: return shadow.breakpoint_vals[$urandom_range(0, n - 1)]
                      + ($urandom_range(0, 1) ? 1 : -1);
            default:
            begin
                if (n < 2)
                    return $urandom;
                i = $urandom_range(0, n - 2);
                lo = longint'(shadow.breakpoint_vals[i]);
                span = longint'(shadow.breakpoint_vals[i + 1]) - lo;
                if (span <= 0)
                    return shadow.breakpoint_vals[i];
                return VALUE_W'(lo + (longint'($urandom) % span));
            end
        endcase
    endfunction

    task load_table(int mode);
        int vals [$];
        int base;
        int start;
        vals.delete();
        start = $urandom_range(0, TABLE_DEPTH - 1);
        base = int'($urandom_range(0, 2000)) - 1000;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (mode == 1)
                vals.push_back(base + int'($urandom_range(0, 60)));
            else
                vals.push_back(int'($urandom));
        end
        if (mode != 2)
            vals.sort();
        if (mode == 3)
        begin
            vals[0] = -2147483647 - 1;
            vals[TABLE_DEPTH - 1] = 2147483647;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            send_word(KIND_WRITE, ENTRY_W'((start + i) % TABLE_DEPTH),
                      vals[(start + i) % TABLE_DEPTH]);
        end
    endtask

    task random_phase();
        logic [CFG_W-1:0] pts;
        int mode;
        int count;
        logic [CFG_W-1:0] first_points [5];
        first_points = '{CFG_W'(1), CFG_W'(0), CFG_W'(31), CFG_W'(2), CFG_W'(16)};
        wait_idle();
        if (phase_count < 5)
        begin
            pts = first_points[phase_count];
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: pts = CFG_W'(0);
                1: pts = CFG_W'(1);
                2: pts = CFG_W'(16);
                3: pts = CFG_W'(31);
                4: pts = CFG_W'($urandom_range(17, 31));
                default: pts = CFG_W'($urandom_range(2, 16));
            endcase
        end
        phase_count++;
        set_points(pts);
        case ($urandom_range(0, 9))
            0, 1: mode = 1;
            2: mode = 2;
            3, 4: mode = 3;
            default: mode = 0;
        endcase
        load_table(mode);
        count = $urandom_range(20, 60);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(KIND_WRITE, ENTRY_W'($urandom),
                          $urandom_range(0, 1) ? $urandom : pick_target());
            else
                send_word(KIND_LOOKUP, ENTRY_W'($urandom), pick_target());
        end
    endtask

    initial
    begin
        shadow = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed table covering the full value range, duplicate entry included
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            send_word(KIND_WRITE, ENTRY_W'(i), directed_points[i]);
        end
        send_word(KIND_LOOKUP, 4'hf, 32'sh80000000);
        send_word(KIND_LOOKUP, 4'h0, 32'sh7fffffff);
        send_word(KIND_LOOKUP, 4'h5, 0);
        send_word(KIND_LOOKUP, 4'ha, 128);
        send_word(KIND_LOOKUP, 4'h3, 254);
        send_word(KIND_LOOKUP, 4'hc, -2000000000);
        send_word(KIND_LOOKUP, 4'h6, 65536);
        send_word(KIND_LOOKUP, 4'h9, 2147483646);
        while (words_sent < WORD_TARGET)
            random_phase();
        wait_idle();
        if (mismatch_count == 0 && shadow.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ breakpoint_index_fraction_search.f @@
rtl/bifs_pkg.sv
rtl/breakpoint_index_fraction_search.sv
tb/breakpoint_index_fraction_search_tb.sv
